>>> rtl/core/tww_pkg.sv
// Shared types, constants and tables for the twist-to-wheel command block.
// Used by the controller, the datapath, the divider and the top level.
package tww_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int STEP_W       = 5;
  localparam int DIV_W        = 48;
  localparam int DVS_W        = 16;
  localparam int DIV_CNT_W    = 6;

  localparam logic [2:0] CFG_MAX_STEER     = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED     = 3'd1;
  localparam logic [2:0] CFG_MIN_SPEED     = 3'd2;
  localparam logic [2:0] CFG_WHEEL_BASE    = 3'd3;
  localparam logic [2:0] CFG_TRACK_WIDTH   = 3'd4;
  localparam logic [2:0] CFG_WHEEL_RADIUS  = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd6;

  localparam logic signed [15:0] STEER_SMALL = 16'sd81;
  localparam logic signed [15:0] STEER_DIFF  = 16'sd819;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_TICK,
    CMD_DIV_Q,
    CMD_DIV_H,
    CMD_DIV_RL,
    CMD_DIV_RR,
    CMD_C_INIT,
    CMD_C_STEP,
    CMD_STEER,
    CMD_MUL1,
    CMD_MUL2,
    CMD_WHEELS,
    CMD_COMMIT
  } dp_cmd_t;

  typedef struct packed {
    logic lx_zero;
    logic div_done;
    logic cordic_last;
    logic diff_on;
  } dp_stat_t;

  // arctangent of 2^-i, radians Q16
  function automatic logic [16:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [16:0] a;
    case (i)
      5'd0:  a = 17'd51472;
      5'd1:  a = 17'd30386;
      5'd2:  a = 17'd16055;
      5'd3:  a = 17'd8150;
      5'd4:  a = 17'd4091;
      5'd5:  a = 17'd2047;
      5'd6:  a = 17'd1024;
      5'd7:  a = 17'd512;
      5'd8:  a = 17'd256;
      5'd9:  a = 17'd128;
      5'd10: a = 17'd64;
      5'd11: a = 17'd32;
      5'd12: a = 17'd16;
      5'd13: a = 17'd8;
      5'd14: a = 17'd4;
      5'd15: a = 17'd2;
      5'd16: a = 17'd1;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/tww_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on tww_pkg for widths.
module tww_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tww_pkg::DIV_W-1:0]     dividend,
  input  logic [tww_pkg::DVS_W-1:0]     divisor,
  output logic                          done,
  output logic [tww_pkg::DIV_W-1:0]     quotient
);

  logic                            busy_r;
  logic                            done_r;
  logic [tww_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [tww_pkg::DIV_W-1:0]       dvd_r, dvd_nxt;
  logic [tww_pkg::DVS_W-1:0]       rem_r, rem_nxt;
  logic [tww_pkg::DVS_W-1:0]       dvs_r;
  logic [tww_pkg::DVS_W:0]         rem_sh, rem_sub;
  logic                            qbit;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[tww_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    qbit    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = qbit ? rem_sub[tww_pkg::DVS_W-1:0] : rem_sh[tww_pkg::DVS_W-1:0];
    dvd_nxt = {dvd_r[tww_pkg::DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tww_pkg::DIV_CNT_W'(tww_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> rtl/core/tww_ctrl.sv
// Sequencer for the twist-to-wheel block: walks a command word through
// division, CORDIC and rate steps, and owns the handshakes. Uses tww_pkg.
module tww_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tww_pkg::dp_stat_t stat,
  output tww_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_TICK, S_Q_START, S_Q_WAIT, S_C_INIT, S_C_STEP, S_STEER,
    S_MUL1, S_MUL2, S_H_START, S_H_WAIT, S_WHEELS, S_RL_START, S_RL_WAIT,
    S_RR_START, S_RR_WAIT, S_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    case (state_r)
      S_IDLE:     cmd = (in_tvalid && !in_kind) ? tww_pkg::CMD_LOAD : tww_pkg::CMD_NONE;
      S_TICK:     cmd = slot_free ? tww_pkg::CMD_TICK : tww_pkg::CMD_NONE;
      S_Q_START:  cmd = stat.lx_zero ? tww_pkg::CMD_NONE : tww_pkg::CMD_DIV_Q;
      S_C_INIT:   cmd = tww_pkg::CMD_C_INIT;
      S_C_STEP:   cmd = tww_pkg::CMD_C_STEP;
      S_STEER:    cmd = tww_pkg::CMD_STEER;
      S_MUL1:     cmd = tww_pkg::CMD_MUL1;
      S_MUL2:     cmd = tww_pkg::CMD_MUL2;
      S_H_START:  cmd = stat.diff_on ? tww_pkg::CMD_DIV_H : tww_pkg::CMD_NONE;
      S_WHEELS:   cmd = tww_pkg::CMD_WHEELS;
      S_RL_START: cmd = tww_pkg::CMD_DIV_RL;
      S_RR_START: cmd = tww_pkg::CMD_DIV_RR;
      S_COMMIT:   cmd = tww_pkg::CMD_COMMIT;
      default:    cmd = tww_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= in_kind ? S_TICK : S_Q_START;
          end
        end
        S_TICK: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_Q_START: state_r <= stat.lx_zero ? S_STEER : S_Q_WAIT;
        S_Q_WAIT: begin
          if (stat.div_done) begin
            state_r <= S_C_INIT;
          end
        end
        S_C_INIT: state_r <= S_C_STEP;
        S_C_STEP: begin
          if (stat.cordic_last) begin
            state_r <= S_STEER;
          end
        end
        S_STEER:   state_r <= S_MUL1;
        S_MUL1:    state_r <= S_MUL2;
        S_MUL2:    state_r <= S_H_START;
        S_H_START: state_r <= stat.diff_on ? S_H_WAIT : S_WHEELS;
        S_H_WAIT: begin
          if (stat.div_done) begin
            state_r <= S_WHEELS;
          end
        end
        S_WHEELS:   state_r <= S_RL_START;
        S_RL_START: state_r <= S_RL_WAIT;
        S_RL_WAIT: begin
          if (stat.div_done) begin
            state_r <= S_RR_START;
          end
        end
        S_RR_START: state_r <= S_RR_WAIT;
        S_RR_WAIT: begin
          if (stat.div_done) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/tww_dp.sv
// Datapath: configuration registers, held outputs, tick counter, CORDIC
// vectoring unit, multipliers and the shared divider. Uses tww_pkg, tww_div.
module tww_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tww_pkg::dp_cmd_t  cmd,
  output tww_pkg::dp_stat_t stat,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [31:0]       in_data,
  output logic [79:0]       out_data
);

  logic [13:0] max_steer_r;
  logic [14:0] max_speed_r, min_speed_r;
  logic [15:0] wheel_base_r, track_width_r, wheel_radius_r, timeout_r;

  logic signed [15:0] held_ls_r, held_rs_r;
  logic signed [23:0] held_lr_r, held_rr_r;
  logic [15:0]        ticks_r, ticks_nxt;
  logic signed [15:0] out_ls_r, out_rs_r;
  logic signed [23:0] out_lr_r, out_rr_r;

  logic signed [15:0] lx_r;
  logic signed [32:0] prod_r;
  logic               sign_r;
  logic signed [34:0] x_r, y_r;
  logic signed [18:0] z_r;
  logic [tww_pkg::STEP_W-1:0] i_r;
  logic signed [15:0] steer_r, wa_r;
  logic signed [16:0] v_r;
  logic signed [33:0] p1_r;
  logic signed [49:0] p2_r;
  logic signed [36:0] left_r, right_r;
  logic signed [23:0] rate_l_r;

  logic                       div_start, div_done;
  logic [tww_pkg::DIV_W-1:0]  div_dvd, div_q;
  logic [tww_pkg::DVS_W-1:0]  div_dvs;

  logic [31:0] prod_abs;
  logic [15:0] lx_abs;
  logic [49:0] p2_abs;
  logic [35:0] left_abs, right_abs;
  logic [15:0] base_eff, radius_eff;

  logic [22:0]        q_mag;
  logic signed [23:0] q_s;
  logic signed [34:0] xs, ys;
  logic signed [18:0] at;
  logic signed [18:0] z_rnd;
  logic signed [16:0] s_neg, ms;
  logic signed [15:0] steer_nxt;
  logic signed [16:0] lx17, mx17, mn17, v_nxt;
  logic signed [36:0] h_s;
  logic               diff_on;

  function automatic logic signed [23:0] sat_rate(input logic [tww_pkg::DIV_W-1:0] m,
                                                  input logic neg);
    logic signed [23:0] r;
    if (neg) begin
      r = (m > 48'd8388608) ? 24'sh800000 : -$signed(m[23:0]);
    end else begin
      r = (m > 48'd8388607) ? 24'sh7FFFFF : $signed(m[23:0]);
    end
    return r;
  endfunction

  tww_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    prod_abs   = prod_r[32] ? 32'(-prod_r) : prod_r[31:0];
    lx_abs     = lx_r[15] ? 16'(-lx_r) : lx_r;
    p2_abs     = p2_r[49] ? 50'(-p2_r) : 50'(p2_r);
    left_abs   = left_r[36] ? 36'(-left_r) : left_r[35:0];
    right_abs  = right_r[36] ? 36'(-right_r) : right_r[35:0];
    base_eff   = (wheel_base_r == 16'd0) ? 16'd1 : wheel_base_r;
    radius_eff = (wheel_radius_r == 16'd0) ? 16'd1 : wheel_radius_r;

    div_start = 1'b1;
    div_dvd   = '0;
    div_dvs   = radius_eff;
    case (cmd)
      tww_pkg::CMD_DIV_Q: begin
        div_dvd = 48'(prod_abs);
        div_dvs = lx_abs;
      end
      tww_pkg::CMD_DIV_H: begin
        div_dvd = 48'(p2_abs[49:14]);
        div_dvs = base_eff;
      end
      tww_pkg::CMD_DIV_RL: div_dvd = {left_abs, 12'd0};
      tww_pkg::CMD_DIV_RR: div_dvd = {right_abs, 12'd0};
      default: div_start = 1'b0;
    endcase

    // saturate the quotient to +-(2^23-1)
    q_mag = (div_q > 48'd8388607) ? 23'h7FFFFF : div_q[22:0];
    q_s   = sign_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({2'b00, tww_pkg::atan_q16(i_r)});

    z_rnd = z_r + 19'sd4;
    s_neg = -$signed(17'(z_rnd >>> 3));
    ms    = $signed({3'b000, max_steer_r});
    if (s_neg > ms) begin
      steer_nxt = 16'(ms);
    end else if (s_neg < -ms) begin
      steer_nxt = 16'(-ms);
    end else begin
      steer_nxt = 16'(s_neg);
    end
    if (lx_r == 16'sd0) begin
      steer_nxt = '0;
    end

    lx17 = 17'(lx_r);
    mx17 = $signed({2'b00, max_speed_r});
    mn17 = $signed({2'b00, min_speed_r});
    if (lx17 > mx17) begin
      v_nxt = mx17;
    end else if (lx17 < -mx17) begin
      v_nxt = -mx17;
    end else if (lx17 > 17'sd0 && lx17 < mn17) begin
      v_nxt = lx17 + mn17;
    end else if (lx17 < 17'sd0 && lx17 > -mn17) begin
      v_nxt = lx17 - mn17;
    end else begin
      v_nxt = lx17;
    end

    diff_on = (steer_r > tww_pkg::STEER_DIFF) || (steer_r < -tww_pkg::STEER_DIFF);
    h_s     = p2_r[49] ? -$signed({2'b00, div_q[34:0]}) : $signed({2'b00, div_q[34:0]});
    if (!diff_on) begin
      h_s = '0;
    end

    ticks_nxt = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steer_r    <= '0;
      max_speed_r    <= '0;
      min_speed_r    <= 15'd492;
      wheel_base_r   <= 16'd2322;
      track_width_r  <= 16'd1831;
      wheel_radius_r <= 16'd410;
      timeout_r      <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        tww_pkg::CFG_MAX_STEER:     max_steer_r    <= cfg_data[13:0];
        tww_pkg::CFG_MAX_SPEED:     max_speed_r    <= cfg_data[14:0];
        tww_pkg::CFG_MIN_SPEED:     min_speed_r    <= cfg_data[14:0];
        tww_pkg::CFG_WHEEL_BASE:    wheel_base_r   <= cfg_data;
        tww_pkg::CFG_TRACK_WIDTH:   track_width_r  <= cfg_data;
        tww_pkg::CFG_WHEEL_RADIUS:  wheel_radius_r <= cfg_data;
        tww_pkg::CFG_TIMEOUT_TICKS: timeout_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // held state and tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_ls_r <= '0;
      held_rs_r <= '0;
      held_lr_r <= '0;
      held_rr_r <= '0;
      ticks_r   <= '0;
    end else if (cmd == tww_pkg::CMD_TICK) begin
      ticks_r <= ticks_nxt;
      if (ticks_nxt > timeout_r) begin
        held_ls_r <= '0;
        held_rs_r <= '0;
        held_lr_r <= '0;
        held_rr_r <= '0;
      end
    end else if (cmd == tww_pkg::CMD_COMMIT) begin
      ticks_r   <= '0;
      held_ls_r <= wa_r;
      held_rs_r <= wa_r;
      held_lr_r <= rate_l_r;
      held_rr_r <= sat_rate(div_q, sign_r);
    end
  end

  // output word register; loaded only while the output slot is free
  always_ff @(posedge clk) begin
    if (cmd == tww_pkg::CMD_TICK) begin
      if (ticks_nxt > timeout_r) begin
        out_ls_r <= '0;
        out_rs_r <= '0;
        out_lr_r <= '0;
        out_rr_r <= '0;
      end else begin
        out_ls_r <= held_ls_r;
        out_rs_r <= held_rs_r;
        out_lr_r <= held_lr_r;
        out_rr_r <= held_rr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      tww_pkg::CMD_LOAD: begin
        lx_r   <= $signed(in_data[15:0]);
        prod_r <= $signed({1'b0, wheel_base_r}) * $signed(in_data[31:16]);
      end
      tww_pkg::CMD_DIV_Q: sign_r <= prod_r[32] ^ lx_r[15];
      tww_pkg::CMD_C_INIT: begin
        x_r <= 35'sd1048576;
        y_r <= 35'(q_s) <<< 8;
        z_r <= '0;
        i_r <= '0;
      end
      tww_pkg::CMD_C_STEP: begin
        if (y_r > 35'sd0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
        i_r <= i_r + 1'b1;
      end
      tww_pkg::CMD_STEER: begin
        steer_r <= steer_nxt;
        wa_r    <= (steer_nxt > tww_pkg::STEER_SMALL || steer_nxt < -tww_pkg::STEER_SMALL)
                   ? steer_nxt : 16'sd0;
        v_r     <= v_nxt;
      end
      tww_pkg::CMD_MUL1: p1_r <= $signed({1'b0, track_width_r}) * v_r;
      tww_pkg::CMD_MUL2: p2_r <= p1_r * steer_r;
      tww_pkg::CMD_WHEELS: begin
        left_r  <= 37'(v_r) - h_s;
        right_r <= 37'(v_r) + h_s;
      end
      tww_pkg::CMD_DIV_RL: sign_r <= left_r[36];
      tww_pkg::CMD_DIV_RR: begin
        rate_l_r <= sat_rate(div_q, sign_r);
        sign_r   <= right_r[36];
      end
      default: ;
    endcase
  end

  assign stat.lx_zero     = (lx_r == 16'sd0);
  assign stat.div_done    = div_done;
  assign stat.cordic_last = (i_r == tww_pkg::STEP_W'(tww_pkg::CORDIC_STEPS - 1));
  assign stat.diff_on     = diff_on;
  assign out_data         = {out_rr_r, out_lr_r, out_rs_r, out_ls_r};

endmodule

>>> rtl/core/twist_to_wheel_command.sv
// Twist-to-wheel command block, top level: joins the sequencer and the datapath.
// Depends on tww_pkg, tww_ctrl, tww_dp (and tww_div below it).
//
// Input words carry a kind in in_tuser: a motion command (linear_x, angular_z)
// or a timer tick. A command updates the held steering angles and rear wheel
// rates and produces no output word. A tick advances the tick counter, zeroes
// the held values once the timeout is passed, and emits one output word.
// A command runs up to four passes of the 48-step serial divider, plus 14
// CORDIC iterations and the multiply and setup steps. Zero speed skips the
// quotient and CORDIC; a steer within 0.1 rad skips the differential division.
// A tick waits in S_TICK until the output slot is free, and its word is then
// loaded into the output register.
// One word is in flight at a time; in_tready is high only when idle.
// If the receiver stalls, the output word holds and a following tick waits
// until the output register is taken; commands carry on regardless.
// Configuration writes are always ready and should be made while idle.
// Reset restores the register defaults and clears held values and counter.
module twist_to_wheel_command (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] linear_x, [31:16] angular_z
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] left_steer, [31:16] right_steer, [55:32] left_rate, [79:56] right_rate
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tww_pkg::dp_cmd_t  cmd;
  tww_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tww_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tww_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_tdata),
    .out_data  (out_tdata)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for twist_to_wheel_command: streams motion commands
// and timer ticks, predicts every tick's output word and compares it field by field.
// Depends on tww_pkg and the twist_to_wheel_command RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [15:0] lx;
    logic [15:0] az;
  } twist_t;

  typedef struct {
    logic [15:0] lsteer;
    logic [15:0] rsteer;
    logic [23:0] lrate;
    logic [23:0] rrate;
  } wheel_cmd_t;

  localparam longint QUOT_LIM = 8388607;
  localparam longint RATE_MAX = 8388607;
  localparam longint RATE_MIN = -8388608;
  localparam longint STEER_TINY = 81;
  localparam longint STEER_SPLIT = 819;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint ATAN_Q16 [20] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = tww_pkg::CFG_MAX_STEER;
  logic [15:0] cfg_data = '0;

  twist_t     cmd_stream [$];
  wheel_cmd_t awaited_words [$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       in_fire = 1'b0;
  longint     cycles = 0;

  // predictor copy of configuration and held state
  longint m_max_steer = 0, m_max_speed = 0, m_min_speed = 492, m_wheel_base = 2322;
  longint m_track = 1831, m_radius = 410, m_timeout = 10;
  longint h_lsteer = 0, h_rsteer = 0, h_lrate = 0, h_rrate = 0, h_ticks = 0;

  twist_to_wheel_command u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint steer_angle(longint lx, longint az);
    longint q, x, y, z, s, xs, ys;
    if (lx == 0) return 0;
    q = (m_wheel_base * az) / lx;
    if (q > QUOT_LIM) q = QUOT_LIM;
    if (q < -QUOT_LIM) q = -QUOT_LIM;
    x = longint'(1) << 20;
    y = q * 256;
    z = 0;
    for (int i = 0; i < tww_pkg::CORDIC_STEPS && i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_Q16[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_Q16[i];
      end
    end
    s = -((z + 4) >>> 3);
    if (s > m_max_steer) s = m_max_steer;
    if (s < -m_max_steer) s = -m_max_steer;
    return s;
  endfunction

  function automatic longint wheel_rate(longint w);
    longint r, q;
    r = (m_radius != 0) ? m_radius : 1;
    q = (w * 4096) / r;
    if (q > RATE_MAX) q = RATE_MAX;
    if (q < RATE_MIN) q = RATE_MIN;
    return q;
  endfunction

  // advance the predictor by one accepted word; returns 1 when a tick emits
  function automatic bit apply_twist(twist_t t, output wheel_cmd_t w);
    longint lx, az, st, v, lft, rgt, b, h;
    w = '{default: '0};
    if (t.kind) begin
      if (h_ticks < 65535) h_ticks++;
      if (h_ticks > m_timeout) begin
        h_lsteer = 0; h_rsteer = 0; h_lrate = 0; h_rrate = 0;
      end
      w.lsteer = h_lsteer[15:0];
      w.rsteer = h_rsteer[15:0];
      w.lrate  = h_lrate[23:0];
      w.rrate  = h_rrate[23:0];
      return 1'b1;
    end
    lx = longint'($signed(t.lx));
    az = longint'($signed(t.az));
    st = steer_angle(lx, az);
    h_ticks = 0;
    h_lsteer = (st > STEER_TINY || st < -STEER_TINY) ? st : 0;
    h_rsteer = h_lsteer;
    if (lx > m_max_speed) v = m_max_speed;
    else if (lx < -m_max_speed) v = -m_max_speed;
    else if (lx > 0 && lx < m_min_speed) v = lx + m_min_speed;
    else if (lx < 0 && lx > -m_min_speed) v = lx - m_min_speed;
    else v = lx;
    lft = v;
    rgt = v;
    if (st > STEER_SPLIT || st < -STEER_SPLIT) begin
      b = (m_wheel_base != 0) ? m_wheel_base : 1;
      h = (m_track * v * st) / (b * 16384);
      lft = v - h;
      rgt = v + h;
    end
    h_lrate = wheel_rate(lft);
    h_rrate = wheel_rate(rgt);
    return 1'b0;
  endfunction

  function automatic void check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // sampling side: input acceptance, configuration writes and output checks
  always @(posedge clk) begin
    twist_t     t;
    wheel_cmd_t w;
    in_fire = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      cycles++;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tww_pkg::CFG_MAX_STEER:     m_max_steer  = cfg_data[13:0];
          tww_pkg::CFG_MAX_SPEED:     m_max_speed  = cfg_data[14:0];
          tww_pkg::CFG_MIN_SPEED:     m_min_speed  = cfg_data[14:0];
          tww_pkg::CFG_WHEEL_BASE:    m_wheel_base = cfg_data;
          tww_pkg::CFG_TRACK_WIDTH:   m_track      = cfg_data;
          tww_pkg::CFG_WHEEL_RADIUS:  m_radius     = cfg_data;
          tww_pkg::CFG_TIMEOUT_TICKS: m_timeout    = cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        t.kind = in_tuser;
        t.lx = in_tdata[15:0];
        t.az = in_tdata[31:16];
        if (apply_twist(t, w)) awaited_words.push_back(w);
      end
      if (out_tvalid && out_tready) begin
        if (awaited_words.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none actual %0h", $time, out_tdata);
        end else begin
          w = awaited_words.pop_front();
          check_field("left_steer", 24'(w.lsteer), 24'(out_tdata[15:0]));
          check_field("right_steer", 24'(w.rsteer), 24'(out_tdata[31:16]));
          check_field("left_rate", w.lrate, out_tdata[55:32]);
          check_field("right_rate", w.rrate, out_tdata[79:56]);
        end
      end
    end
  end

  // stream driver: hold a word until taken, then advance or idle
  always @(negedge clk) begin
    twist_t t;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_tvalid || in_fire) begin
        if (cmd_stream.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          t = cmd_stream.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= t.kind;
          in_tdata  <= {t.az, t.lx};
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= $urandom();
          in_tuser  <= 1'($urandom_range(1));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("twist_to_wheel_command regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 16'($urandom());
  endtask

  task automatic write_all(longint v [7]);
    cfg_write(tww_pkg::CFG_MAX_STEER, 16'(v[0]));
    cfg_write(tww_pkg::CFG_MAX_SPEED, 16'(v[1]));
    cfg_write(tww_pkg::CFG_MIN_SPEED, 16'(v[2]));
    cfg_write(tww_pkg::CFG_WHEEL_BASE, 16'(v[3]));
    cfg_write(tww_pkg::CFG_TRACK_WIDTH, 16'(v[4]));
    cfg_write(tww_pkg::CFG_WHEEL_RADIUS, 16'(v[5]));
    cfg_write(tww_pkg::CFG_TIMEOUT_TICKS, 16'(v[6]));
  endtask

  // drain: nothing queued, nothing held, nothing awaited, then let a command finish
  task automatic drain();
    do @(posedge clk); while (cmd_stream.size() != 0 || in_tvalid || awaited_words.size() != 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      1: return 16'($signed($urandom_range(1200)) - 600);
      2: return 16'($signed($urandom_range(8000)) - 4000);
      3: return 16'($urandom_range(1) ? 0 : ($urandom_range(1) ? 1 : 16'hffff));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic longint cfg_pick(longint lo, longint hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return longint'($urandom_range(int'(hi), int'(lo)));
    endcase
  endfunction

  task automatic push_twist(logic kind, logic [15:0] lx, logic [15:0] az);
    twist_t t;
    t.kind = kind;
    t.lx = lx;
    t.az = az;
    cmd_stream.push_back(t);
  endtask

  task automatic push_random(int n);
    int runlen;
    while (n > 0) begin
      if ($urandom_range(99) < 15) begin
        // tick burst of timeout to timeout+3 ticks when the timeout is small, so it may cross it
        runlen = (m_timeout < 22) ? int'(m_timeout) + $urandom_range(3) : $urandom_range(6) + 1;
        repeat (runlen) push_twist(1'b1, 16'($urandom()), 16'($urandom()));
        n -= runlen;
      end else begin
        push_twist($urandom_range(99) < 45, pick16(), pick16());
        n--;
      end
    end
  endtask

  initial begin
    longint cfg_v [7];
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: full-range limits, field extremes, zero speed, timeout
    cfg_v = '{12868, 32767, 492, 2322, 1831, 410, 3};
    write_all(cfg_v);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'h0000, 16'h7fff);
    push_twist(1'b1, 16'hffff, 16'hffff);
    push_twist(1'b0, 16'h7fff, 16'h7fff);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'h8000, 16'h8000);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'h0001, 16'h8000);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'hffff, 16'h7fff);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'h7fff, 16'h0000);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'd100, 16'd3);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'd1000, 16'd40);
    push_twist(1'b1, 16'h0000, 16'h0000);
    push_twist(1'b0, 16'hfc18, 16'd900);
    repeat (6) push_twist(1'b1, 16'h0000, 16'h0000);
    drain();

    for (int p = 1; p <= 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (p)
        1: ; // keep the directed limits
        2: begin cfg_v = '{0, 0, 32767, 1, 65535, 1, 0}; write_all(cfg_v); end
        3: begin cfg_v = '{12868, 32767, 0, 65535, 0, 65535, 65535}; write_all(cfg_v); end
        4: begin cfg_v = '{12868, 20000, 2000, 0, 65535, 0, 5}; write_all(cfg_v); end
        default: begin
          cfg_v[0] = cfg_pick(0, 12868);
          cfg_v[1] = cfg_pick(0, 32767);
          cfg_v[2] = cfg_pick(0, 32767);
          cfg_v[3] = cfg_pick(1, 65535);
          cfg_v[4] = cfg_pick(0, 65535);
          cfg_v[5] = cfg_pick(1, 65535);
          cfg_v[6] = ($urandom_range(3) == 0) ? cfg_pick(0, 65535) : $urandom_range(20);
          write_all(cfg_v);
        end
      endcase
      push_random(180);
      drain();
    end

    if (errors == 0) begin
      $display("twist_to_wheel_command regression: pass");
    end else begin
      $display("twist_to_wheel_command regression: fail");
    end
    $finish;
  end

endmodule

>>> twist_to_wheel_command.f
rtl/core/tww_pkg.sv
rtl/core/tww_div.sv
rtl/core/tww_ctrl.sv
rtl/core/tww_dp.sv
rtl/core/twist_to_wheel_command.sv
verif/tb_top.sv
